[hdl/lmlt_pkg.sv]
// Shared types, register indexes and timing constants for the LCD mode and line timing block.
package lmlt_pkg;

    localparam int ELAPSED_W = 8;
    localparam int LIMIT_W   = 9;
    localparam int COUNT_W   = 10;
    localparam int LINE_W    = 8;
    localparam int SUM_W     = COUNT_W + 1;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int OUT_DATA_W = 16;

    localparam logic [LINE_W-1:0]  LINE_VBLANK_START = 8'd144;
    localparam logic [LINE_W-1:0]  LINE_LAST         = 8'd153;
    localparam logic [COUNT_W-1:0] COUNT_MAX         = 10'd1023;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_DISPLAY_ENABLE  = 3'd0;
    localparam logic [2:0] REG_LINE_COMPARE    = 3'd1;
    localparam logic [2:0] REG_COINC_IRQ_EN    = 3'd2;
    localparam logic [2:0] REG_HBLANK_LIMIT    = 3'd3;
    localparam logic [2:0] REG_VBLANK_LIMIT    = 3'd4;
    localparam logic [2:0] REG_OAM_LIMIT       = 3'd5;
    localparam logic [2:0] REG_TRANSFER_LIMIT  = 3'd6;

    typedef enum logic [1:0] {
        LCD_HBLANK   = 2'd0,
        LCD_VBLANK   = 2'd1,
        LCD_OAM_SCAN = 2'd2,
        LCD_DRAW     = 2'd3
    } mode_t;

    typedef struct packed {
        logic               display_enable;
        logic [LINE_W-1:0]  line_compare;
        logic               coinc_irq_enable;
        logic [LIMIT_W-1:0] hblank_limit;
        logic [LIMIT_W-1:0] vblank_limit;
        logic [LIMIT_W-1:0] oam_limit;
        logic [LIMIT_W-1:0] transfer_limit;
    } cfg_t;

    typedef struct packed {
        mode_t             mode;
        logic [LINE_W-1:0] line;
        logic              coincidence;
        logic              vblank_irq;
        logic              lcd_irq;
        logic              render_line;
        logic              frame_done;
    } result_t;

endpackage

[hdl/lcd_mode_line_timing.sv]
// Top level of the LCD mode and line timing block: input and result registers around the core.
//
//  channel  | dir | fields (low bit up)
//  s_axis   | in  | tdata: elapsed_cycles[7:0]
//  m_axis   | out | tdata: mode[1:0] line[9:2] coincidence[10] vblank_irq[11]
//           |     |        lcd_irq[12] render_line[13] frame_done[14] zero[15]
//  apb      | in  | regs 0..6 at byte address 4*i
//
// One transfer per cycle sustained while the result is taken; an item passes
// the input register, then the result register. The core adds, compares and
// advances mode combinationally between them; timing state updates as an
// item moves on. A stalled result holds its register and the input register,
// which still takes one item. Reset (rst_n low, asynchronous) restores
// registers and state: line 0, OAM search, counter 0.
module lcd_mode_line_timing
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // elapsed_cycles[7:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lmlt_pkg::OUT_DATA_W-1:0]   m_tdata,   // mode, line, coincidence, pulses
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lmlt_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lmlt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lmlt_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    lmlt_pkg::cfg_t                 cfg;
    lmlt_pkg::result_t              result;
    lmlt_pkg::result_t              out_reg;
    logic                           in_valid_reg;
    logic [lmlt_pkg::ELAPSED_W-1:0] in_data_reg;
    logic                           out_valid_reg;
    logic                           advance;
    logic                           step;

    lmlt_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // handshake: the result register empties or is being taken
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata;
        end
    end

    lmlt_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .step    (step),
        .elapsed (in_data_reg),
        .result  (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign m_tdata[1:0] = out_reg.mode;
    assign m_tdata[9:2] = out_reg.line;
    assign m_tdata[10]  = out_reg.coincidence;
    assign m_tdata[11]  = out_reg.vblank_irq;
    assign m_tdata[12]  = out_reg.lcd_irq;
    assign m_tdata[13]  = out_reg.render_line;
    assign m_tdata[14]  = out_reg.frame_done;
    assign m_tdata[15]  = 1'b0;

endmodule

[hdl/lmlt_regs.sv]
// APB configuration registers for the LCD mode and line timing block.
module lmlt_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lmlt_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lmlt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lmlt_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output lmlt_pkg::cfg_t                    cfg
);

    lmlt_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [2:0]     reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel & penable & pwrite;
    assign reg_index = paddr[4:2];
    assign cfg       = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.display_enable   <= 1'b1;
            cfg_reg.line_compare     <= '0;
            cfg_reg.coinc_irq_enable <= 1'b0;
            cfg_reg.hblank_limit     <= 9'd204;
            cfg_reg.vblank_limit     <= 9'd456;
            cfg_reg.oam_limit        <= 9'd80;
            cfg_reg.transfer_limit   <= 9'd172;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                lmlt_pkg::REG_DISPLAY_ENABLE: cfg_reg.display_enable   <= pwdata[0];
                lmlt_pkg::REG_LINE_COMPARE:
                    cfg_reg.line_compare <= pwdata[lmlt_pkg::LINE_W-1:0];
                lmlt_pkg::REG_COINC_IRQ_EN:   cfg_reg.coinc_irq_enable <= pwdata[0];
                lmlt_pkg::REG_HBLANK_LIMIT:
                    cfg_reg.hblank_limit <= pwdata[lmlt_pkg::LIMIT_W-1:0];
                lmlt_pkg::REG_VBLANK_LIMIT:
                    cfg_reg.vblank_limit <= pwdata[lmlt_pkg::LIMIT_W-1:0];
                lmlt_pkg::REG_OAM_LIMIT:
                    cfg_reg.oam_limit <= pwdata[lmlt_pkg::LIMIT_W-1:0];
                lmlt_pkg::REG_TRANSFER_LIMIT:
                    cfg_reg.transfer_limit <= pwdata[lmlt_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        prdata = '0;
        unique case (reg_index)
            lmlt_pkg::REG_DISPLAY_ENABLE: prdata[0] = cfg_reg.display_enable;
            lmlt_pkg::REG_LINE_COMPARE:
                prdata[lmlt_pkg::LINE_W-1:0] = cfg_reg.line_compare;
            lmlt_pkg::REG_COINC_IRQ_EN:   prdata[0] = cfg_reg.coinc_irq_enable;
            lmlt_pkg::REG_HBLANK_LIMIT:
                prdata[lmlt_pkg::LIMIT_W-1:0] = cfg_reg.hblank_limit;
            lmlt_pkg::REG_VBLANK_LIMIT:
                prdata[lmlt_pkg::LIMIT_W-1:0] = cfg_reg.vblank_limit;
            lmlt_pkg::REG_OAM_LIMIT:
                prdata[lmlt_pkg::LIMIT_W-1:0] = cfg_reg.oam_limit;
            lmlt_pkg::REG_TRANSFER_LIMIT:
                prdata[lmlt_pkg::LIMIT_W-1:0] = cfg_reg.transfer_limit;
            default: prdata = '0;
        endcase
    end

endmodule

[hdl/lmlt_core.sv]
// Timing state and combinational mode/line update for one elapsed-cycles transfer.
module lmlt_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  lmlt_pkg::cfg_t                    cfg,
    input  logic                              step,
    input  logic [lmlt_pkg::ELAPSED_W-1:0]    elapsed,
    output lmlt_pkg::result_t                 result
);

    logic [lmlt_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [lmlt_pkg::LINE_W-1:0]  line_reg, line_next;
    lmlt_pkg::mode_t              mode_reg, mode_next;
    logic                         coinc_reg, coinc_next;

    logic [lmlt_pkg::LIMIT_W-1:0] limit;
    logic [lmlt_pkg::SUM_W-1:0]   sum;
    logic [lmlt_pkg::SUM_W-1:0]   rem;
    logic                         reached;
    logic [lmlt_pkg::LINE_W-1:0]  line_inc;
    logic                         line_change;
    logic                         match;
    logic                         vblank_irq, lcd_irq, render_line, frame_done;

    // limit of the current mode
    always_comb
    begin
        unique case (mode_reg)
            lmlt_pkg::LCD_HBLANK:   limit = cfg.hblank_limit;
            lmlt_pkg::LCD_VBLANK:   limit = cfg.vblank_limit;
            lmlt_pkg::LCD_OAM_SCAN: limit = cfg.oam_limit;
            lmlt_pkg::LCD_DRAW:     limit = cfg.transfer_limit;
            default:                limit = cfg.transfer_limit;
        endcase
    end

    // accumulate and test against the limit
    assign sum      = {1'b0, count_reg}
                    + {{(lmlt_pkg::SUM_W-lmlt_pkg::ELAPSED_W){1'b0}}, elapsed};
    assign reached  = (sum >= {{(lmlt_pkg::SUM_W-lmlt_pkg::LIMIT_W){1'b0}}, limit});
    assign rem      = reached
                    ? sum - {{(lmlt_pkg::SUM_W-lmlt_pkg::LIMIT_W){1'b0}}, limit} : sum;
    assign line_inc = line_reg + 8'd1;

    // mode advance
    always_comb
    begin
        mode_next   = mode_reg;
        line_next   = line_reg;
        line_change = 1'b0;
        vblank_irq  = 1'b0;
        render_line = 1'b0;
        frame_done  = 1'b0;
        if (cfg.display_enable && reached)
        begin
            unique case (mode_reg)
                lmlt_pkg::LCD_HBLANK:
                begin
                    line_next   = line_inc;
                    line_change = 1'b1;
                    if (line_inc < lmlt_pkg::LINE_VBLANK_START)
                    begin
                        mode_next = lmlt_pkg::LCD_OAM_SCAN;
                    end
                    else
                    begin
                        mode_next  = lmlt_pkg::LCD_VBLANK;
                        vblank_irq = 1'b1;
                    end
                end
                lmlt_pkg::LCD_VBLANK:
                begin
                    line_next   = line_inc;
                    line_change = 1'b1;
                    if (line_inc > lmlt_pkg::LINE_LAST)
                    begin
                        line_next  = '0;
                        frame_done = 1'b1;
                        mode_next  = lmlt_pkg::LCD_OAM_SCAN;
                    end
                end
                lmlt_pkg::LCD_OAM_SCAN:
                begin
                    mode_next = lmlt_pkg::LCD_DRAW;
                end
                default:
                begin
                    mode_next   = lmlt_pkg::LCD_HBLANK;
                    render_line = 1'b1;
                end
            endcase
        end
    end

    // coincidence check on a line change
    assign match      = (line_next == cfg.line_compare);
    assign coinc_next = line_change ? match : coinc_reg;
    assign lcd_irq    = line_change & match & cfg.coinc_irq_enable;

    // counter update with saturation
    always_comb
    begin
        count_next = count_reg;
        if (cfg.display_enable)
        begin
            if (rem > {1'b0, lmlt_pkg::COUNT_MAX})
            begin
                count_next = lmlt_pkg::COUNT_MAX;
            end
            else
            begin
                count_next = rem[lmlt_pkg::COUNT_W-1:0];
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            line_reg  <= '0;
            mode_reg  <= lmlt_pkg::LCD_OAM_SCAN;
            coinc_reg <= 1'b0;
        end
        else if (step)
        begin
            count_reg <= count_next;
            line_reg  <= line_next;
            mode_reg  <= mode_next;
            coinc_reg <= coinc_next;
        end
    end

    assign result.mode        = mode_next;
    assign result.line        = line_next;
    assign result.coincidence = coinc_next;
    assign result.vblank_irq  = vblank_irq;
    assign result.lcd_irq     = lcd_irq;
    assign result.render_line = render_line;
    assign result.frame_done  = frame_done;

    // a frame wrap lands on line zero in OAM search
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        step && frame_done |=> line_reg == '0 && mode_reg == lmlt_pkg::LCD_OAM_SCAN)
        else $error("frame wrap did not return to line zero in OAM search");

    // a frozen display keeps all timing state
    a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        step && !cfg.display_enable |=> $stable(count_reg) && $stable(line_reg)
            && $stable(mode_reg) && $stable(coinc_reg))
        else $error("timing state moved while display disabled");

    // only one mode advance per transfer
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({vblank_irq, render_line, frame_done}))
        else $error("more than one mode event in one transfer");

    // end of pixel transfer enters horizontal blank
    a_render_hblank: assert property (@(posedge clk) disable iff (!rst_n)
        step && render_line |=> mode_reg == lmlt_pkg::LCD_HBLANK)
        else $error("render pulse without entering horizontal blank");

endmodule
